// ----- sv/bdasc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdasc_pkg: shared types and constants
// widths of the binary input, the bcd chain and the counters, plus the
// control struct that drives each digit cell
// ----------------------------------------------------------------------------
package bdasc_pkg;

  localparam int unsigned BIN_W     = 64;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned CHAR_W    = 6;
  localparam int unsigned STEP_W    = $clog2(BIN_W + 1);
  localparam int unsigned REM_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [STEP_W-1:0] STEPS_TOTAL = STEP_W'(BIN_W);
  localparam logic [REM_W-1:0]  DIGITS_TOTAL = REM_W'(NUM_DIGITS);
  localparam logic [REM_W-1:0]  ONE_LEFT     = REM_W'(1);
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = CHAR_W'(48);
  localparam logic [NIB_W-1:0]  NIB_ZERO     = '0;

  typedef logic [NIB_W-1:0] nib_t;
  typedef nib_t [NUM_DIGITS-1:0] bcd_t;

  // per-cell control: clear starts a new item, step does one shift-add-3
  typedef struct packed {
    logic clr;
    logic step;
  } cell_ctl_t;

endpackage

// ----- sv/bdasc_cell.sv -----
// ----------------------------------------------------------------------------
// bdasc_cell: one bcd digit of the double-dabble chain
// adds 3 when the digit is 5 or more, then shifts in the carry from below
// ----------------------------------------------------------------------------
module bdasc_cell (
  input  logic                clk,
  input  bdasc_pkg::cell_ctl_t ctl,
  input  logic                carry_in,
  output logic                carry_out,
  output bdasc_pkg::nib_t     digit
);

  bdasc_pkg::nib_t nib_r;
  bdasc_pkg::nib_t nib_nxt;
  bdasc_pkg::nib_t adj;

  always_comb begin
    adj       = (nib_r >= bdasc_pkg::NIB_W'(5)) ? nib_r + bdasc_pkg::NIB_W'(3) : nib_r;
    carry_out = adj[bdasc_pkg::NIB_W-1];
    nib_nxt   = nib_r;
    if (ctl.clr) begin
      nib_nxt = bdasc_pkg::NIB_ZERO;
    end else if (ctl.step) begin
      nib_nxt = {adj[bdasc_pkg::NIB_W-2:0], carry_in};
    end
  end

  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
  end

  assign digit = nib_r;

endmodule

// ----- sv/bdasc_conv.sv -----
// ----------------------------------------------------------------------------
// bdasc_conv: binary to bcd converter
// a row of digit cells fed one input bit per cycle, msb first
// ----------------------------------------------------------------------------
module bdasc_conv (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic [bdasc_pkg::BIN_W-1:0]        value,
  input  logic                               take,
  output logic                               res_valid,
  output logic                               idle,
  output bdasc_pkg::bcd_t                    res
);

  logic [bdasc_pkg::BIN_W-1:0]  bin_r;
  logic [bdasc_pkg::BIN_W-1:0]  bin_nxt;
  logic [bdasc_pkg::STEP_W-1:0] cnt_r;
  logic [bdasc_pkg::STEP_W-1:0] cnt_nxt;
  logic                         valid_r;
  logic                         valid_nxt;
  logic                         stepping;
  bdasc_pkg::cell_ctl_t         ctl;
  logic [bdasc_pkg::NUM_DIGITS:0] carry;

  assign stepping  = valid_r && (cnt_r != '0);
  assign res_valid = valid_r && (cnt_r == '0);
  assign idle      = !valid_r;
  assign ctl.clr   = load;
  assign ctl.step  = stepping;
  assign carry[0]  = bin_r[bdasc_pkg::BIN_W-1];

  for (genvar d = 0; d < bdasc_pkg::NUM_DIGITS; d++) begin : g_cell
    bdasc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .carry_in  (carry[d]),
      .carry_out (carry[d+1]),
      .digit     (res[d])
    );
  end

  always_comb begin
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (load) begin
      bin_nxt   = value;
      cnt_nxt   = bdasc_pkg::STEPS_TOTAL;
      valid_nxt = 1'b1;
    end else begin
      if (stepping) begin
        bin_nxt = {bin_r[bdasc_pkg::BIN_W-2:0], 1'b0};
        cnt_nxt = cnt_r - bdasc_pkg::STEP_W'(1);
      end
      if (take) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
  end

endmodule

// ----- sv/bdasc_emit.sv -----
// ----------------------------------------------------------------------------
// bdasc_emit: digit emitter
// holds one converted number, drops leading zeros one a cycle and sends
// the remaining digits as ascii, most significant first
// ----------------------------------------------------------------------------
module bdasc_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  bdasc_pkg::bcd_t                   bcd,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [bdasc_pkg::CHAR_W-1:0]      out_char,
  output logic                              out_last,
  output logic                              free
);

  bdasc_pkg::bcd_t              buf_r;
  bdasc_pkg::bcd_t              buf_nxt;
  logic [bdasc_pkg::REM_W-1:0]  rem_r;
  logic [bdasc_pkg::REM_W-1:0]  rem_nxt;
  logic                         busy_r;
  logic                         busy_nxt;
  logic                         lead_r;
  logic                         lead_nxt;
  bdasc_pkg::nib_t              top;
  logic                         skip;
  logic                         sent;

  assign top       = buf_r[bdasc_pkg::NUM_DIGITS-1];
  assign out_last  = (rem_r == bdasc_pkg::ONE_LEFT);
  assign out_valid = busy_r && (!lead_r || (top != bdasc_pkg::NIB_ZERO) || out_last);
  assign out_char  = bdasc_pkg::ASCII_ZERO + bdasc_pkg::CHAR_W'(top);
  assign skip      = busy_r && !out_valid;
  assign sent      = out_valid && out_ready;
  assign free      = !busy_r || (sent && out_last);

  always_comb begin
    buf_nxt  = buf_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    lead_nxt = lead_r;
    if (load) begin
      buf_nxt  = bcd;
      rem_nxt  = bdasc_pkg::DIGITS_TOTAL;
      busy_nxt = 1'b1;
      lead_nxt = 1'b1;
    end else if (skip || sent) begin
      buf_nxt = {buf_r[bdasc_pkg::NUM_DIGITS-2:0], bdasc_pkg::NIB_ZERO};
      rem_nxt = rem_r - bdasc_pkg::ONE_LEFT;
      if (sent) begin
        lead_nxt = 1'b0;
        if (out_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      lead_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      lead_r <= lead_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

// ----- sv/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 64-bit unsigned binary to decimal ascii text
// double-dabble conversion in a chain of twenty bcd digit cells, followed
// by a digit emitter that streams the digits msb first without leading zeros
// ----------------------------------------------------------------------------
//  channel | ports              | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_tvalid/tready   | in_tdata[63:0] value
//  out     | out_tvalid/tready  | out_tdata[5:0] digit_char, out_tlast last_digit
//
//  an item in the cell chain takes a load that clears the cells, then
//  64 shift steps, one input bit shifted per cycle
//  the chain can take a new item while the previous number's
//  1 to 20 digits leave through the emitter; leading zeros drop out one per cycle
//  reset (rst_n low, synchronous) empties the chain and the emitter
//  a stalled output holds the emitter; the chain keeps converting and then
//  waits with its result until the emitter has sent its last digit
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic        out_tlast   // last_digit
);

  logic                           conv_res_valid;
  logic                           conv_idle;
  bdasc_pkg::bcd_t                conv_res;
  logic                           emit_free;
  logic                           handoff;
  logic                           in_accept;
  logic [bdasc_pkg::CHAR_W-1:0]   digit_char;

  // result moves to the emitter as soon as it is free, possibly in the same
  // cycle as the emitter's last digit leaves
  assign handoff   = conv_res_valid && emit_free;
  // chain takes a new item when empty or when its result leaves this cycle
  assign in_tready = conv_idle || handoff;
  assign in_accept = in_tvalid && in_tready;

  bdasc_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .value     (in_tdata),
    .take      (handoff),
    .res_valid (conv_res_valid),
    .idle      (conv_idle),
    .res       (conv_res)
  );

  bdasc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (handoff),
    .bcd       (conv_res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_char  (digit_char),
    .out_last  (out_tlast),
    .free      (emit_free)
  );

  // pad the 6-bit character to a whole byte
  assign out_tdata = {2'b00, digit_char};

  // the chain is busy for its shift steps right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again during conversion");

  // every emitted character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] >= 6'd48) && (out_tdata[5:0] <= 6'd57))
    else $error("emitted character is not a decimal digit");

  // a handoff never overwrites a number still being sent
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !handoff)
    else $error("emitter reloaded while a digit is pending");

endmodule
